FILE: sv/hsrv_pkg.sv
// Shared types, constants and lookup functions for the status report validator.
package hsrv_pkg;

	localparam int unsigned PosW = 6;
	localparam logic [PosW-1:0] ReportLen = 6'd32;
	localparam logic [PosW-1:0] PosSat = 6'd33;
	localparam logic MasterSideReset = 1'b1;

	localparam logic [1:0] VERDICT_REJECT = 2'd0;
	localparam logic [1:0] VERDICT_STATUS = 2'd1;
	localparam logic [1:0] VERDICT_BOOT = 2'd2;

	// flag byte bits
	localparam int unsigned FlagMicKnown = 0;
	localparam int unsigned FlagMicMuted = 1;
	localparam int unsigned FlagOutKnown = 2;
	localparam int unsigned FlagOutMuted = 3;
	localparam int unsigned FlagWsKnown = 4;
	localparam int unsigned FlagMediaKnown = 5;
	localparam logic [7:0] FlagResvMask = 8'hc0;

	localparam logic [7:0] StatusVersion = 8'd1;
	localparam logic [7:0] LevelMax = 8'd100;
	localparam logic [7:0] PlaybackMax = 8'd2;
	localparam logic [7:0] PrintLow = 8'h20;
	localparam logic [7:0] PrintHigh = 8'h7e;

	typedef struct packed {
		logic [PosW-1:0] pos;
		logic [7:0]      flags;
		logic            status_ok;
		logic            boot_match;
		logic            label_ended;
	} rpt_state_t;

	localparam rpt_state_t RptStateReset = '{
		pos: '0, flags: '0, status_ok: 1'b1, boot_match: 1'b1, label_ended: 1'b0
	};

	// expected byte of the bootloader request; zero padding past the text
	function automatic logic [7:0] boot_char(input logic [4:0] p);
		logic [7:0] c;
		case (p)
			5'd0:    c = 8'h43;
			5'd1:    c = 8'h4f;
			5'd2:    c = 8'h52;
			5'd3:    c = 8'h4e;
			5'd4:    c = 8'h45;
			5'd5:    c = 8'h5f;
			5'd6:    c = 8'h42;
			5'd7:    c = 8'h4f;
			5'd8:    c = 8'h4f;
			5'd9:    c = 8'h54;
			5'd10:   c = 8'h4c;
			5'd11:   c = 8'h4f;
			5'd12:   c = 8'h41;
			5'd13:   c = 8'h44;
			5'd14:   c = 8'h45;
			5'd15:   c = 8'h52;
			5'd16:   c = 8'h5f;
			5'd17:   c = 8'h56;
			5'd18:   c = 8'h31;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] magic_char(input logic [1:0] p);
		logic [7:0] c;
		case (p)
			2'd0:    c = 8'h4f;
			2'd1:    c = 8'h4c;
			2'd2:    c = 8'h45;
			default: c = 8'h44;
		endcase
		return c;
	endfunction

endpackage

FILE: sv/hsrv_byte_check.sv
// Per-byte field checks and report bookkeeping for one incoming byte.
module hsrv_byte_check (
	input  hsrv_pkg::rpt_state_t cur,
	input  logic [7:0]           report_byte,
	input  logic                 last_byte,
	input  logic                 master_side,
	output hsrv_pkg::rpt_state_t nxt,
	output logic [1:0]           verdict
);

	hsrv_pkg::rpt_state_t upd;
	logic                 ended;
	logic                 known;
	logic [7:0]           b;

	assign b = report_byte;

	always_comb begin
		upd = cur;
		ended = cur.label_ended;
		known = 1'b0;
		if (cur.pos < hsrv_pkg::ReportLen) begin
			if (b != hsrv_pkg::boot_char(cur.pos[4:0]))
				upd.boot_match = 1'b0;
			if (cur.pos < 6'd4) begin
				if (b != hsrv_pkg::magic_char(cur.pos[1:0]))
					upd.status_ok = 1'b0;
			end else if (cur.pos == 6'd4) begin
				if (b != hsrv_pkg::StatusVersion)
					upd.status_ok = 1'b0;
			end else if (cur.pos == 6'd5) begin
				upd.flags = b;
				if ((b & hsrv_pkg::FlagResvMask) != 8'd0
						|| (b[hsrv_pkg::FlagMicMuted] && !b[hsrv_pkg::FlagMicKnown])
						|| (b[hsrv_pkg::FlagOutMuted] && !b[hsrv_pkg::FlagOutKnown]))
					upd.status_ok = 1'b0;
			end else if (cur.pos == 6'd6) begin
				if (b > hsrv_pkg::LevelMax
						|| (!cur.flags[hsrv_pkg::FlagOutKnown] && b != 8'd0))
					upd.status_ok = 1'b0;
			end else if (cur.pos == 6'd7) begin
				if (b > hsrv_pkg::PlaybackMax
						|| (!cur.flags[hsrv_pkg::FlagMediaKnown] && b != 8'd0))
					upd.status_ok = 1'b0;
			end else begin
				// labels: an unknown label starts out already ended
				if (cur.pos == 6'd8) begin
					known = cur.flags[hsrv_pkg::FlagWsKnown];
					ended = !known;
					if (known && b == 8'd0)
						upd.status_ok = 1'b0;
				end else if (cur.pos == 6'd16) begin
					ended = !cur.flags[hsrv_pkg::FlagMediaKnown];
				end
				if (b == 8'd0) begin
					ended = 1'b1;
				end else if (ended || b < hsrv_pkg::PrintLow || b > hsrv_pkg::PrintHigh) begin
					upd.status_ok = 1'b0;
				end
				upd.label_ended = ended;
			end
		end
		upd.pos = (cur.pos < hsrv_pkg::PosSat) ? cur.pos + 6'd1 : hsrv_pkg::PosSat;

		verdict = hsrv_pkg::VERDICT_REJECT;
		if (cur.pos == hsrv_pkg::ReportLen - 6'd1) begin
			if (upd.boot_match)
				verdict = hsrv_pkg::VERDICT_BOOT;
			else if (upd.status_ok && master_side)
				verdict = hsrv_pkg::VERDICT_STATUS;
		end

		nxt = last_byte ? hsrv_pkg::RptStateReset : upd;
	end

endmodule

FILE: sv/hid_status_report_validator.sv
// Top level of the status report validator: input register, byte checks, verdict register.
// Takes one report byte per cycle unless stalled and gives one verdict on each byte marked
// last: 2 for the exact 32-byte bootloader request, 1 for a well-formed 32-byte status
// report while master_side is set, 0 otherwise. Throughput is one byte every cycle unless
// stalled; a byte is checked in the cycle after its transfer (one input register, then
// the check logic into the verdict register), so a verdict follows its last byte through
// both registers. in_stall rises only when a verdict is waiting in the output register,
// the output is stalled and the byte in the input register is itself a last byte.
module hid_status_report_validator (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] report_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] verdict,
	input  logic       cfg_we,
	input  logic       cfg_wdata
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 last_s1;
	hsrv_pkg::rpt_state_t state_q;
	hsrv_pkg::rpt_state_t state_nxt;
	logic                 master_side_q;
	logic                 out_valid_q;
	logic [1:0]           verdict_q;
	logic [1:0]           verdict_nxt;
	logic                 advance;
	logic                 in_take;

	assign advance = !valid_s1 || !last_s1 || !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_take = in_valid && !in_stall;

	hsrv_byte_check u_check (
		.cur         (state_q),
		.report_byte (byte_s1),
		.last_byte   (last_s1),
		.master_side (master_side_q),
		.nxt         (state_nxt),
		.verdict     (verdict_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_side_q <= hsrv_pkg::MasterSideReset;
		end else if (cfg_we) begin
			master_side_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= report_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hsrv_pkg::RptStateReset;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && last_s1 && advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && last_s1 && advance)
			verdict_q <= verdict_nxt;
	end

	assign out_valid = out_valid_q;
	assign verdict = verdict_q;

	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (verdict_q <= hsrv_pkg::VERDICT_BOOT))
		else $error("verdict holds an unused code");

	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.pos <= hsrv_pkg::PosSat)
		else $error("byte position ran past saturation");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1 && advance) |=> (state_q == hsrv_pkg::RptStateReset))
		else $error("report state not cleared after a verdict");

	a_status_needs_master: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1 && advance && verdict_nxt == hsrv_pkg::VERDICT_STATUS)
		|-> master_side_q)
		else $error("status report accepted on a slave half");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !(valid_s1 && last_s1 && advance))
		else $error("verdict overwritten while stalled");

endmodule
